@@ sv/nlq_pkg.sv @@
// shared types and constants for the nearest level quantizer
package nlq_pkg;

  localparam int VALUE_BITS = 32;
  localparam int INDEX_BITS = 8;
  localparam int COUNT_BITS = 9;

  localparam logic [COUNT_BITS-1:0] LEVEL_COUNT_RESET = 9'd256;

  typedef enum logic [0:0] {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t                     req_type;
    logic [INDEX_BITS-1:0]         level_index;
    logic signed [VALUE_BITS-1:0]  level_value;
    logic signed [VALUE_BITS-1:0]  sample;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  quantized_value;
    logic [INDEX_BITS-1:0]         chosen_index;
  } out_item_t;

endpackage

@@ sv/nlq_table.sv @@
// level table: synchronous memory, one write port and one registered read port
module nlq_table #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [ADDR_W-1:0]                   waddr,
  input  logic signed [nlq_pkg::VALUE_BITS-1:0] wdata,
  input  logic                                re,
  input  logic [ADDR_W-1:0]                   raddr,
  output logic signed [nlq_pkg::VALUE_BITS-1:0] rdata
);

  logic signed [nlq_pkg::VALUE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/nlq_search.sv @@
// binary search sequencer: one table probe per cycle, keeps the closest midpoint
module nlq_search #(
  parameter int ADDR_W  = 8,
  parameter int COUNT_W = 9
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  go,
  input  logic [COUNT_W-1:0]                    count,
  input  logic signed [nlq_pkg::VALUE_BITS-1:0] sample,
  output logic                                  busy,
  output logic                                  re,
  output logic [ADDR_W-1:0]                     raddr,
  input  logic signed [nlq_pkg::VALUE_BITS-1:0] rdata,
  output logic                                  done,
  output nlq_pkg::out_item_t                    result
);

  localparam int VB = nlq_pkg::VALUE_BITS;

  typedef enum logic {
    IDLE,
    PROBE
  } state_t;

  state_t                state;
  logic [COUNT_W-1:0]    lo;
  logic [COUNT_W-1:0]    hi_ex;
  logic [ADDR_W-1:0]     mid;
  logic signed [VB-1:0]  smp;
  logic [VB:0]           best_gap;
  logic [ADDR_W-1:0]     best_idx;
  logic signed [VB-1:0]  best_val;
  logic                  first;

  logic signed [VB:0]    diff;
  logic [VB:0]           gap;
  logic                  take;
  logic                  go_up;
  logic [COUNT_W-1:0]    lo_next;
  logic [COUNT_W-1:0]    hi_ex_next;
  logic [COUNT_W-1:0]    mid_wide;
  logic [ADDR_W-1:0]     mid_next;
  logic                  more;
  logic [ADDR_W-1:0]     sel_idx;
  logic signed [VB-1:0]  sel_val;

  // gap and direction for the probed level
  always_comb begin
    diff  = {smp[VB-1], smp} - {rdata[VB-1], rdata};
    gap   = diff[VB] ? (VB+1)'(-diff) : (VB+1)'(diff);
    take  = first || (gap < best_gap);
    go_up = rdata < smp;
    sel_idx = take ? mid : best_idx;
    sel_val = take ? rdata : best_val;
  end

  // next bounds, hi_ex is one past the last candidate
  always_comb begin
    if (go_up) begin
      lo_next    = COUNT_W'(mid) + COUNT_W'(1);
      hi_ex_next = hi_ex;
    end else begin
      lo_next    = lo;
      hi_ex_next = COUNT_W'(mid);
    end
    more     = lo_next < hi_ex_next;
    mid_wide = lo_next + ((hi_ex_next - COUNT_W'(1) - lo_next) >> 1);
    mid_next = mid_wide[ADDR_W-1:0];
  end

  logic [COUNT_W-1:0] mid0_wide;
  assign mid0_wide = (count - COUNT_W'(1)) >> 1;

  assign busy = (state != IDLE);

  always_comb begin
    re    = 1'b0;
    raddr = mid_next;
    unique case (state)
      IDLE: begin
        re    = go;
        raddr = mid0_wide[ADDR_W-1:0];
      end
      PROBE: begin
        re    = more;
        raddr = mid_next;
      end
      default: begin
        re    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
      first <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (go) begin
            state <= PROBE;
            lo    <= '0;
            hi_ex <= count;
            mid   <= mid0_wide[ADDR_W-1:0];
            smp   <= sample;
            first <= 1'b1;
          end
        end
        PROBE: begin
          first    <= 1'b0;
          best_idx <= sel_idx;
          best_val <= sel_val;
          if (take) begin
            best_gap <= gap;
          end
          lo    <= lo_next;
          hi_ex <= hi_ex_next;
          mid   <= mid_next;
          if (!more) begin
            state                  <= IDLE;
            done                   <= 1'b1;
            result.quantized_value <= sel_val;
            result.chosen_index    <= nlq_pkg::INDEX_BITS'(sel_idx);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/nearest_level_quantizer.sv @@
// Nearest level quantizer. A load beat (req_type load) writes one level into the table
// and leaves busy low. A sample beat runs a binary search over the first
// level_count entries (0 reads as 1, values above MAX_LEVELS saturate). After the accept
// cycle, busy stays high while the search probes the table memory's read port; how many
// probes it makes depends on the path the search takes. The result is driven for exactly
// one cycle with done high, in the first cycle with busy low again; the receiver cannot
// stall it, and a new beat may be started in that same cycle. The closest probed level
// wins, the earlier probe on a tie. Levels are expected in ascending order and must be
// loaded before a search reaches them.
module nearest_level_quantizer #(
  parameter int MAX_LEVELS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  nlq_pkg::in_item_t                    req,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [nlq_pkg::COUNT_BITS-1:0]       cfg_data,
  output logic                                 done,
  output nlq_pkg::out_item_t                   result
);

  localparam int ADDR_W  = $clog2(MAX_LEVELS);
  localparam int COUNT_W = $clog2(MAX_LEVELS + 1);

  logic [nlq_pkg::COUNT_BITS-1:0] level_count;
  logic [COUNT_W-1:0]             count_sat;
  logic                           accept;
  logic                           we;
  logic                           go;
  logic                           re;
  logic [ADDR_W-1:0]              raddr;
  logic signed [nlq_pkg::VALUE_BITS-1:0] rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= nlq_pkg::LEVEL_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      level_count <= cfg_data;
    end
  end

  always_comb begin
    if (level_count == '0) begin
      count_sat = COUNT_W'(1);
    end else if (32'(level_count) > MAX_LEVELS) begin
      count_sat = COUNT_W'(MAX_LEVELS);
    end else begin
      count_sat = COUNT_W'(level_count);
    end
  end

  assign accept = start && !busy;
  // loads beyond the table depth are dropped
  assign we = accept && (req.req_type == nlq_pkg::REQ_LOAD)
              && (32'(req.level_index) < MAX_LEVELS);
  assign go = accept && (req.req_type == nlq_pkg::REQ_SAMPLE);

  nlq_table #(
    .DEPTH  (MAX_LEVELS),
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (ADDR_W'(req.level_index)),
    .wdata (req.level_value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  nlq_search #(
    .ADDR_W  (ADDR_W),
    .COUNT_W (COUNT_W)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .count  (count_sat),
    .sample (req.sample),
    .busy   (busy),
    .re     (re),
    .raddr  (raddr),
    .rdata  (rdata),
    .done   (done),
    .result (result)
  );

endmodule
